// ----- sv/bba_pkg.sv -----
package bba_pkg;

    // Map geometry
    localparam int NUM_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = NUM_BLOCKS / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);

    // Field widths
    localparam int BLK_W = 12;
    localparam int CNT_W = 13;
    localparam int OP_W  = 2;
    localparam int RUN_W = CNT_W + 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic wr_setup;
        logic wr_word;
        logic finish;
    } bba_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_alloc;
        logic op_run;
        logic alloc_bad;
        logic hit;
        logic scan_last;
        logic range_empty;
        logic wr_last;
        logic out_free;
    } bba_sts_t;

endpackage

// ----- sv/bba_if.sv -----
interface bba_req_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [BLK_W-1:0] start_block;
    logic [CNT_W-1:0] run_length;

    modport source (output valid, operation, start_block, run_length, input ready);
    modport sink   (input valid, operation, start_block, run_length, output ready);
endinterface

interface bba_res_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic             ok;
    logic [BLK_W-1:0] granted_block;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;

    modport source (output valid, ok, granted_block, used_count, free_count, input ready);
    modport sink   (input valid, ok, granted_block, used_count, free_count, output ready);
endinterface

// ----- sv/bba_ctrl.sv -----
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bba_pkg::bba_sts_t sts,
    output bba_pkg::bba_cmd_t cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_START,
        S_SCAN,
        S_SETUP,
        S_READ,
        S_MODIFY,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one request through scan and run update
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (sts.op_alloc)
                    state_next = sts.alloc_bad ? S_FINISH : S_SCAN_START;
                else if (sts.op_run)
                    state_next = S_SETUP;
                else
                    state_next = S_FINISH;
            end
            S_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                priority if (sts.hit)
                    state_next = S_SETUP;
                else if (sts.scan_last)
                    state_next = S_FINISH;
                else
                    state_next = S_SCAN;
            end
            S_SETUP:
            begin
                cmd.wr_setup = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                state_next = sts.range_empty ? S_FINISH : S_MODIFY;
            end
            S_MODIFY:
            begin
                cmd.wr_word = 1'b1;
                state_next  = sts.wr_last ? S_FINISH : S_READ;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/bba_datapath.sv -----
module bba_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
    input  logic [bba_pkg::OP_W-1:0]  operation,
    input  logic [bba_pkg::BLK_W-1:0] start_block,
    input  logic [bba_pkg::CNT_W-1:0] run_length,
    input  logic                      res_ready,
    output logic                      res_valid,
    output logic                      ok,
    output logic [bba_pkg::BLK_W-1:0] granted_block,
    output logic [bba_pkg::CNT_W-1:0] used_count,
    output logic [bba_pkg::CNT_W-1:0] free_count,
    input  bba_pkg::bba_cmd_t         cmd,
    output bba_pkg::bba_sts_t         sts
);
    import bba_pkg::*;

    // Mask with the lowest n bits set
    function automatic logic [WORD_BITS-1:0] low_ones(input logic [BIT_W:0] n);
        logic [WORD_BITS-1:0] r;
        for (int i = 0; i < WORD_BITS; i++)
            r[i] = ((BIT_W+1)'(i) < n);
        return r;
    endfunction

    // Count of clear bits from the top down to the highest set bit
    function automatic logic [BIT_W:0] top_free(input logic [WORD_BITS-1:0] u);
        logic [BIT_W:0] n;
        n = (BIT_W+1)'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++)
            if (u[i])
                n = (BIT_W+1)'(WORD_BITS - 1 - i);
        return n;
    endfunction

    // Used map and per-word valid flags
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic [WADDR_W-1:0]   rd_addr;

    // Configuration and counters
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_eff;
    logic [CNT_W-1:0] used_reg;

    // Request and working registers
    logic [OP_W-1:0]    op_reg;
    logic [BLK_W-1:0]   start_reg;
    logic [CNT_W-1:0]   len_reg;
    logic               ok_reg;
    logic [BLK_W-1:0]   grant_reg;
    logic               set_reg;
    logic [BLK_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   hi_reg;
    logic [WADDR_W-1:0] waddr_reg;
    logic [WADDR_W-1:0] last_reg;
    logic [WADDR_W-1:0] scan_word_reg;
    logic [CNT_W-1:0]   found_reg;

    // Result register
    logic             res_valid_reg;
    logic             res_ok_reg;
    logic [BLK_W-1:0] res_grant_reg;
    logic [CNT_W-1:0] res_used_reg;
    logic [CNT_W-1:0] res_free_reg;

    // Scan signals
    logic [WORD_BITS-1:0] word_q;
    logic [BLK_W-1:0]     base_s;
    logic [CNT_W-1:0]     lim_full;
    logic [BIT_W:0]       lim;
    logic [WORD_BITS-1:0] used_eff;
    logic [WORD_BITS-1:0] hit_vec;
    logic [CNT_W-1:0]     found_next;
    logic [BIT_W-1:0]     hit_idx;
    logic [RUN_W-1:0]     grant_calc;

    // Run update signals
    logic [BLK_W-1:0]     base_w;
    logic [BLK_W-1:0]     lo_diff;
    logic [BIT_W:0]       lo_off;
    logic [CNT_W-1:0]     hi_diff;
    logic [BIT_W:0]       hi_off;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] changed;
    logic [WORD_BITS-1:0] new_word;
    logic [BIT_W:0]       delta;

    // Range setup signals
    logic [CNT_W-1:0] alloc_hi;
    logic [RUN_W-1:0] run_end;
    logic [CNT_W-1:0] run_hi;
    logic [BLK_W-1:0] setup_lo;
    logic [CNT_W-1:0] setup_hi;
    logic [CNT_W-1:0] setup_hi_m1;
    logic [CNT_W-1:0] total_m1;

    // Clamp the configured total to the map size
    assign total_eff = (total_reg > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : total_reg;
    assign total_m1  = total_eff - CNT_W'(1);

    // Words never written read as free
    assign word_q = rd_vld_reg ? rd_data_reg : '0;

    // Treat blocks past the total as used during the scan
    assign base_s   = {scan_word_reg, BIT_W'(0)};
    assign lim_full = total_eff - {1'b0, base_s};
    assign lim      = (lim_full >= CNT_W'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS)
                                                      : lim_full[BIT_W:0];
    assign used_eff = word_q | ~low_ones(lim);

    // Free run length ending at each bit, carried in from earlier words
    always_comb
    begin
        logic [WORD_BITS-1:0] u;
        logic [BIT_W:0]       run;
        logic [RUN_W-1:0]     eff;
        hit_vec    = '0;
        found_next = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            u   = (used_eff << (WORD_BITS - 1 - j))
                | low_ones((BIT_W+1)'(WORD_BITS - 1 - j));
            run = top_free(u);
            if (run == (BIT_W+1)'(j + 1))
                eff = RUN_W'(found_reg) + RUN_W'(j + 1);
            else
                eff = RUN_W'(run);
            hit_vec[j] = (eff >= RUN_W'(len_reg));
            if (j == WORD_BITS - 1)
                found_next = eff[CNT_W-1:0];
        end
    end

    // Pick the lowest bit where the run first reaches the length
    always_comb
    begin
        hit_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
            if (hit_vec[j])
                hit_idx = BIT_W'(j);
    end

    assign grant_calc = RUN_W'(base_s) + RUN_W'(hit_idx) + RUN_W'(1) - RUN_W'(len_reg);

    // Bits of the current word inside [lo, hi)
    assign base_w  = {waddr_reg, BIT_W'(0)};
    assign lo_diff = lo_reg - base_w;
    assign lo_off  = (lo_reg > base_w) ? lo_diff[BIT_W:0] : '0;
    assign hi_diff = hi_reg - {1'b0, base_w};
    assign hi_off  = (hi_diff >= CNT_W'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS)
                                                    : hi_diff[BIT_W:0];
    assign wmask   = low_ones(hi_off) & ~low_ones(lo_off);

    // Set or clear the run and count bits that flip
    assign changed  = wmask & (set_reg ? ~word_q : word_q);
    assign new_word = set_reg ? (word_q | wmask) : (word_q & ~wmask);

    always_comb
    begin
        delta = '0;
        for (int i = 0; i < WORD_BITS; i++)
            delta = delta + (BIT_W+1)'(changed[i]);
    end

    // Clip the run to the total
    assign alloc_hi    = {1'b0, grant_reg} + len_reg;
    assign run_end     = RUN_W'(start_reg) + RUN_W'(len_reg);
    assign run_hi      = (run_end > RUN_W'(total_eff)) ? total_eff : run_end[CNT_W-1:0];
    assign setup_lo    = (op_reg == OP_ALLOC) ? grant_reg : start_reg;
    assign setup_hi    = (op_reg == OP_ALLOC) ? alloc_hi : run_hi;
    assign setup_hi_m1 = setup_hi - CNT_W'(1);

    // Select the map read address
    always_comb
    begin
        priority if (cmd.scan_start)
            rd_addr = '0;
        else if (cmd.scan_step)
            rd_addr = scan_word_reg + WADDR_W'(1);
        else
            rd_addr = waddr_reg;
    end

    // Map memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_word)
            map_mem[waddr_reg] <= new_word;
        rd_data_reg <= map_mem[rd_addr];
        rd_vld_reg  <= row_valid_reg[rd_addr];
    end

    // Control state: word flags, total, used counter, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            total_reg     <= TOTAL_RESET;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                total_reg <= cfg_wdata;
            if (cmd.wr_word)
            begin
                row_valid_reg[waddr_reg] <= 1'b1;
                if (set_reg)
                    used_reg <= used_reg + CNT_W'(delta);
                else
                    used_reg <= used_reg - CNT_W'(delta);
            end
            if (cmd.finish)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            start_reg <= start_block;
            len_reg   <= run_length;
            ok_reg    <= (operation != OP_ALLOC);
            grant_reg <= '0;
        end
        if (cmd.scan_start)
        begin
            scan_word_reg <= '0;
            found_reg     <= '0;
            last_reg      <= total_m1[BLK_W-1:BIT_W];
        end
        if (cmd.scan_step)
        begin
            scan_word_reg <= scan_word_reg + WADDR_W'(1);
            found_reg     <= found_next;
            if (|hit_vec)
            begin
                ok_reg    <= 1'b1;
                grant_reg <= grant_calc[BLK_W-1:0];
            end
        end
        if (cmd.wr_setup)
        begin
            lo_reg    <= setup_lo;
            hi_reg    <= setup_hi;
            waddr_reg <= setup_lo[BLK_W-1:BIT_W];
            last_reg  <= setup_hi_m1[BLK_W-1:BIT_W];
            set_reg   <= (op_reg != OP_RELEASE);
        end
        if (cmd.wr_word)
            waddr_reg <= waddr_reg + WADDR_W'(1);
        if (cmd.finish)
        begin
            res_ok_reg    <= ok_reg;
            res_grant_reg <= grant_reg;
            res_used_reg  <= used_reg;
            res_free_reg  <= (total_eff > used_reg) ? (total_eff - used_reg) : '0;
        end
    end

    // Status
    assign sts.op_alloc    = (op_reg == OP_ALLOC);
    assign sts.op_run      = (op_reg == OP_RELEASE) || (op_reg == OP_RESERVE);
    assign sts.alloc_bad   = (len_reg == '0) || (total_eff == '0);
    assign sts.hit         = |hit_vec;
    assign sts.scan_last   = (scan_word_reg == last_reg);
    assign sts.range_empty = ({1'b0, lo_reg} >= hi_reg);
    assign sts.wr_last     = (waddr_reg == last_reg);
    assign sts.out_free    = !res_valid_reg || res_ready;

    // Outputs
    assign res_valid     = res_valid_reg;
    assign ok            = res_ok_reg;
    assign granted_block = res_grant_reg;
    assign used_count    = res_used_reg;
    assign free_count    = res_free_reg;

endmodule

// ----- sv/bitmap_block_allocator_unit.sv -----
// First-fit block allocator over a 4096-block used map held as 128 words of
// 32 bits, one bit per block, plus a used-block counter. Each request is one
// of allocate (find the lowest run of run_length free blocks below
// total_blocks, mark it used, return its start or ok = 0), release (clear a
// run) or reserve (set a run); release and reserve skip blocks at or past the
// total. Every result carries used_count and free_count after the request.
// Requests are handled one at a time; the result register lets the next
// request in while a result waits. Allocate scans one map word per cycle,
// up to ceil(total/32) words, then reads and rewrites each word the run
// touches, as release and reserve do, after decode and range setup; the
// result loads when its register is free. The map reads as all free after
// reset through per-word valid flags, so no clearing pass is needed.
// Write total_blocks only while no request is in flight.
module bitmap_block_allocator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
    bba_req_if.sink                   request,
    bba_res_if.source                 result
);
    import bba_pkg::*;

    bba_cmd_t cmd;
    bba_sts_t sts;

    // Sequence requests
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold map, counters and result
    bba_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .operation     (request.operation),
        .start_block   (request.start_block),
        .run_length    (request.run_length),
        .res_ready     (result.ready),
        .res_valid     (result.valid),
        .ok            (result.ok),
        .granted_block (result.granted_block),
        .used_count    (result.used_count),
        .free_count    (result.free_count),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ----- sv/bba_checker.sv -----
module bba_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic                      res_ok,
    input logic [bba_pkg::BLK_W-1:0] res_granted,
    input logic [bba_pkg::CNT_W-1:0] res_used,
    input logic [bba_pkg::CNT_W-1:0] res_free
);
    import bba_pkg::*;

    logic [1:0] pending_reg;

    // Track requests whose results are not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if ((req_valid && req_ready) && !(res_valid && res_ready))
            pending_reg <= pending_reg + 2'd1;
        else if (!(req_valid && req_ready) && (res_valid && res_ready))
            pending_reg <= pending_reg - 2'd1;
    end

    // No result without an accepted request
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pending_reg != 2'd0))
        else $error("result shown with no request outstanding");

    // One request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in progress");

    // Failed allocation grants block zero
    a_fail_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ok) |-> (res_granted == '0))
        else $error("failed result carries a nonzero block");

    // Used plus free never exceeds the map size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (({1'b0, res_used} + {1'b0, res_free}) <= RUN_W'(NUM_BLOCKS)))
        else $error("used and free counts exceed map size");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_granted)
                                       && $stable(res_used)))
        else $error("stalled result changed");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_ok      (result.ok),
    .res_granted (result.granted_block),
    .res_used    (result.used_count),
    .res_free    (result.free_count)
);
